// File: hdl/sbp_pkg.sv
// shared types and constants for the seeded byte permutation block
// no dependencies; imported by sbp_rng, sbp_maps and seeded_byte_permutation
`default_nettype none

package sbp_pkg;

    // map geometry: 256 entries of one byte each
    localparam int unsigned MAP_DEPTH = 256;
    localparam int unsigned ADDR_W    = 8;
    localparam int unsigned IDX_W     = 9;

    // generator constants
    localparam int unsigned SEED_W      = 64;
    localparam logic [63:0] PERM_SALT   = 64'h00A5_A5DE_ADBE_EF42;
    localparam logic [63:0] GOLDEN_SEED = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] RNG_MULT    = 64'h2545_F491_4F6C_DD1D;
    localparam int unsigned XS_SHIFT_A  = 12;
    localparam int unsigned XS_SHIFT_B  = 25;
    localparam int unsigned XS_SHIFT_C  = 27;

    // input command codes
    typedef enum logic [1:0] {
        CMD_REBUILD = 2'd0,
        CMD_ENCODE  = 2'd1,
        CMD_DECODE  = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_command;

    // memory read and write requests
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_ram_rd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] data;
    } t_ram_wr;

    // generator control and status
    typedef struct packed {
        logic             load;
        logic             draw;
        logic [IDX_W-1:0] modulus;
    } t_rng_req;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] pick;
    } t_rng_rsp;

endpackage

`default_nettype wire

// File: hdl/sbp_rng.sv
// xorshift64* generator with bit-serial multiply and bit-serial modulo reduction
// depends on sbp_pkg
`default_nettype none

module sbp_rng
    import sbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [SEED_W-1:0] i_seed,
    input  wire t_rng_req          i_req,
    output t_rng_rsp               o_rsp
);

    localparam int unsigned CNT_W = $clog2(SEED_W);

    typedef enum logic [2:0] {
        RS_IDLE,
        RS_XS1,
        RS_XS2,
        RS_XS3,
        RS_MUL,
        RS_MOD,
        RS_DONE
    } t_rng_state;

    t_rng_state        r_state;
    logic [SEED_W-1:0] r_x;
    logic [SEED_W-1:0] r_mul;
    logic [SEED_W-1:0] r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_mod;
    logic [ADDR_W-1:0] r_rem;

    logic [SEED_W-1:0] seed_mix;
    logic [SEED_W-1:0] xs3;
    logic [IDX_W-1:0]  rem_t;
    logic [IDX_W-1:0]  rem_sub;
    logic              last_bit;

    // start value with zero replacement
    assign seed_mix = (((i_seed ^ PERM_SALT) == '0) ? GOLDEN_SEED : (i_seed ^ PERM_SALT));
    assign xs3      = r_x ^ (r_x >> XS_SHIFT_C);

    // one restoring remainder step per cycle, product msb first
    assign rem_t    = {r_rem, r_acc[SEED_W-1]};
    assign rem_sub  = rem_t - r_mod;
    assign last_bit = (r_cnt == CNT_W'(SEED_W - 1));

    // sequencer: three shift steps, 64 multiply steps, 64 remainder steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_x     <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                RS_IDLE: begin
                    if (i_req.load) begin
                        r_x <= seed_mix;
                    end
                    if (i_req.draw) begin
                        r_mod   <= i_req.modulus;
                        r_state <= RS_XS1;
                    end
                end
                RS_XS1: begin
                    r_x     <= r_x ^ (r_x >> XS_SHIFT_A);
                    r_state <= RS_XS2;
                end
                RS_XS2: begin
                    r_x     <= r_x ^ (r_x << XS_SHIFT_B);
                    r_state <= RS_XS3;
                end
                RS_XS3: begin
                    r_x     <= xs3;
                    r_mul   <= xs3;
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_state <= RS_MUL;
                end
                RS_MUL: begin
                    r_acc <= {r_acc[SEED_W-2:0], 1'b0}
                             + (r_mul[SEED_W-1] ? RNG_MULT : '0);
                    r_mul <= {r_mul[SEED_W-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (last_bit) begin
                        r_rem   <= '0;
                        r_state <= RS_MOD;
                    end
                end
                RS_MOD: begin
                    r_rem <= (rem_t >= r_mod) ? rem_sub[ADDR_W-1:0] : rem_t[ADDR_W-1:0];
                    r_acc <= {r_acc[SEED_W-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (last_bit) begin
                        r_state <= RS_DONE;
                    end
                end
                RS_DONE: begin
                    r_state <= RS_IDLE;
                end
                default: begin
                    r_state <= RS_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = (r_state == RS_DONE);
    assign o_rsp.pick = r_rem;

endmodule

`default_nettype wire

// File: hdl/sbp_maps.sv
// forward and inverse byte maps, one read and one write port each, registered read
// depends on sbp_pkg
`default_nettype none

module sbp_maps
    import sbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_ram_rd           i_fwd_rd,
    input  wire t_ram_wr           i_fwd_wr,
    input  wire t_ram_rd           i_inv_rd,
    input  wire t_ram_wr           i_inv_wr,
    output logic [ADDR_W-1:0]      o_fwd_q,
    output logic [ADDR_W-1:0]      o_inv_q
);

    logic [ADDR_W-1:0] r_fwd_mem [MAP_DEPTH];
    logic [ADDR_W-1:0] r_inv_mem [MAP_DEPTH];

    // forward map
    always_ff @(posedge i_clk) begin
        if (i_fwd_rd.en) begin
            o_fwd_q <= r_fwd_mem[i_fwd_rd.addr];
        end
        if (i_fwd_wr.en) begin
            r_fwd_mem[i_fwd_wr.addr] <= i_fwd_wr.data;
        end
    end

    // inverse map
    always_ff @(posedge i_clk) begin
        if (i_inv_rd.en) begin
            o_inv_q <= r_inv_mem[i_inv_rd.addr];
        end
        if (i_inv_wr.en) begin
            r_inv_mem[i_inv_wr.addr] <= i_inv_wr.data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/seeded_byte_permutation.sv
// encode, decode and unused commands: result passes through the lookup stage and the output register,
// one command per cycle while the output drains; lookups are single map reads
// rebuild: 256 fill writes, 255 draws with swaps, then the inverse; its length is
// set by the bit-serial multiply and remainder in the generator; no input meanwhile
// reset: maps read as identity until the first rebuild, seed and generator cleared
// depends on sbp_pkg, sbp_rng, sbp_maps
`default_nettype none

module seeded_byte_permutation
    import sbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_command,
    input  wire logic [7:0]        i_data_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_result_byte,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [SEED_W-1:0] i_shuffle_seed
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_DRAW_REQ,
        ST_DRAW_WAIT,
        ST_SW_RD_HI,
        ST_SW_RD_PICK,
        ST_SW_WR_HI,
        ST_SW_WR_PICK,
        ST_INV,
        ST_INV_LAST,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        LK_ZERO,
        LK_FWD,
        LK_INV,
        LK_IDENT
    } t_lk_kind;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_pick;
    logic [ADDR_W-1:0] r_hold;
    logic              r_inv_pend;
    logic [ADDR_W-1:0] r_inv_j;
    logic              r_built;
    logic [SEED_W-1:0] r_seed;
    logic              r_lk_valid;
    t_lk_kind          r_lk_kind;
    logic [ADDR_W-1:0] r_lk_addr;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_byte;

    t_command          cmd;
    logic              in_accept;
    logic              out_free;
    logic              finish_go;
    logic [IDX_W-1:0]  idx_dec;
    logic [ADDR_W-1:0] idx_m1;
    logic [ADDR_W-1:0] lk_result;
    logic [ADDR_W-1:0] fwd_q;
    logic [ADDR_W-1:0] inv_q;
    t_ram_rd           fwd_rd;
    t_ram_wr           fwd_wr;
    t_ram_rd           inv_rd;
    t_ram_wr           inv_wr;
    t_rng_req          rng_req;
    t_rng_rsp          rng_rsp;

    assign cmd       = t_command'(i_command);
    assign out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && (!r_lk_valid || out_free);
    assign in_accept = i_in_valid && o_in_ready;
    assign finish_go = (r_state == ST_FINISH) && (!r_lk_valid || out_free);
    assign idx_dec   = r_idx - IDX_W'(1);
    assign idx_m1    = idx_dec[ADDR_W-1:0];

    // seed register always takes a transfer
    assign o_cfg_ready = 1'b1;

    // map port control
    always_comb begin
        fwd_rd      = '0;
        fwd_wr      = '0;
        fwd_rd.addr = i_data_byte;
        unique case (r_state)
            ST_IDLE: begin
                fwd_rd.en = in_accept && (cmd == CMD_ENCODE);
            end
            ST_FILL: begin
                fwd_wr.en   = 1'b1;
                fwd_wr.addr = r_idx[ADDR_W-1:0];
                fwd_wr.data = r_idx[ADDR_W-1:0];
            end
            ST_SW_RD_HI: begin
                fwd_rd.en   = 1'b1;
                fwd_rd.addr = idx_m1;
            end
            ST_SW_RD_PICK: begin
                fwd_rd.en   = 1'b1;
                fwd_rd.addr = r_pick;
            end
            ST_SW_WR_HI: begin
                fwd_wr.en   = 1'b1;
                fwd_wr.addr = idx_m1;
                fwd_wr.data = fwd_q;
            end
            ST_SW_WR_PICK: begin
                fwd_wr.en   = 1'b1;
                fwd_wr.addr = r_pick;
                fwd_wr.data = r_hold;
            end
            ST_INV: begin
                fwd_rd.en   = 1'b1;
                fwd_rd.addr = r_idx[ADDR_W-1:0];
            end
            ST_DRAW_REQ, ST_DRAW_WAIT, ST_INV_LAST, ST_FINISH: begin
            end
        endcase

        inv_rd.en   = in_accept && (cmd == CMD_DECODE);
        inv_rd.addr = i_data_byte;
        inv_wr.en   = r_inv_pend;
        inv_wr.addr = fwd_q;
        inv_wr.data = r_inv_j;

        rng_req.load    = in_accept && (cmd == CMD_REBUILD);
        rng_req.draw    = (r_state == ST_DRAW_REQ) && !r_lk_valid;
        rng_req.modulus = r_idx;
    end

    sbp_maps u_maps (
        .i_clk    (i_clk),
        .i_fwd_rd (fwd_rd),
        .i_fwd_wr (fwd_wr),
        .i_inv_rd (inv_rd),
        .i_inv_wr (inv_wr),
        .o_fwd_q  (fwd_q),
        .o_inv_q  (inv_q)
    );

    sbp_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seed  (r_seed),
        .i_req   (rng_req),
        .o_rsp   (rng_rsp)
    );

    // lookup stage result select
    always_comb begin
        unique case (r_lk_kind)
            LK_ZERO:  lk_result = '0;
            LK_FWD:   lk_result = fwd_q;
            LK_INV:   lk_result = inv_q;
            LK_IDENT: lk_result = r_lk_addr;
        endcase
    end

    // rebuild sequencer, lookup stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_inv_pend  <= 1'b0;
            r_built     <= 1'b0;
            r_seed      <= '0;
            r_lk_valid  <= 1'b0;
            r_lk_kind   <= LK_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_inv_pend <= (r_state == ST_INV);

            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_shuffle_seed;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept && (cmd == CMD_REBUILD)) begin
                        r_idx   <= '0;
                        r_state <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    if (r_idx == IDX_W'(MAP_DEPTH - 1)) begin
                        r_idx   <= IDX_W'(MAP_DEPTH);
                        r_state <= ST_DRAW_REQ;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_DRAW_REQ: begin
                    if (!r_lk_valid) begin
                        r_state <= ST_DRAW_WAIT;
                    end
                end
                ST_DRAW_WAIT: begin
                    if (rng_rsp.done) begin
                        r_pick  <= rng_rsp.pick;
                        r_state <= ST_SW_RD_HI;
                    end
                end
                ST_SW_RD_HI: begin
                    r_state <= ST_SW_RD_PICK;
                end
                ST_SW_RD_PICK: begin
                    r_hold  <= fwd_q;
                    r_state <= ST_SW_WR_HI;
                end
                ST_SW_WR_HI: begin
                    r_state <= ST_SW_WR_PICK;
                end
                ST_SW_WR_PICK: begin
                    if (r_idx == IDX_W'(2)) begin
                        r_idx   <= '0;
                        r_state <= ST_INV;
                    end else begin
                        r_idx   <= idx_dec;
                        r_state <= ST_DRAW_REQ;
                    end
                end
                ST_INV: begin
                    r_inv_j <= r_idx[ADDR_W-1:0];
                    if (r_idx == IDX_W'(MAP_DEPTH - 1)) begin
                        r_state <= ST_INV_LAST;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_INV_LAST: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (finish_go) begin
                        r_built <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
            endcase

            // lookup stage
            if (in_accept && (cmd != CMD_REBUILD)) begin
                r_lk_valid <= 1'b1;
                r_lk_addr  <= i_data_byte;
                priority if (cmd == CMD_ENCODE) begin
                    r_lk_kind <= r_built ? LK_FWD : LK_IDENT;
                end else if (cmd == CMD_DECODE) begin
                    r_lk_kind <= r_built ? LK_INV : LK_IDENT;
                end else begin
                    r_lk_kind <= LK_ZERO;
                end
            end else if (finish_go) begin
                r_lk_valid <= 1'b1;
                r_lk_kind  <= LK_ZERO;
            end else if (out_free) begin
                r_lk_valid <= 1'b0;
            end

            // output register
            if (out_free) begin
                r_out_valid <= r_lk_valid;
                if (r_lk_valid) begin
                    r_out_byte <= lk_result;
                end
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_out_byte;

    // shuffle reads never clobber a pending forward lookup
    a_no_rd_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fwd_rd.en && (r_state != ST_IDLE)) |-> !r_lk_valid)
        else $error("forward map read during rebuild while a lookup is pending");

    // a stalled lookup result is kept
    a_lk_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lk_valid && !out_free) |=> r_lk_valid)
        else $error("lookup result lost while output stalled");

    // generator reports only when the sequencer waits for it
    a_rng_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rng_rsp.done |-> (r_state == ST_DRAW_WAIT))
        else $error("generator finished outside a draw");

    // swap partner lies below the current bound
    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SW_RD_HI) |-> ({1'b0, r_pick} < r_idx))
        else $error("shuffle pick out of range");

endmodule

`default_nettype wire

// File: bench/seeded_byte_permutation_tb.sv
// self-checking testbench for seeded_byte_permutation: keyed shuffle, encode and decode lookups
// depends on sbp_pkg for the command codes and the seed width; the dut itself is instance dut
`timescale 1ns / 1ps

import sbp_pkg::*;

// tracks the permutation the block should hold and the result bytes still owed
class byte_map_scoreboard;
    localparam logic [63:0] SEED_SALT   = 64'h00A5_A5DE_ADBE_EF42;
    localparam logic [63:0] ZERO_SUB    = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] DRAW_MULT   = 64'h2545_F491_4F6C_DD1D;
    localparam int          MISMATCH_SHOWN = 10;

    logic [7:0]  fwd_map [256];
    logic [7:0]  inv_map [256];
    logic [63:0] gen_state;
    logic [63:0] seed;
    logic [7:0]  pending_bytes [$];
    int          mismatches;

    function new();
        gen_state  = '0;
        seed       = '0;
        mismatches = 0;
        for (int i = 0; i < 256; i++) begin
            fwd_map[i] = 8'(i);
            inv_map[i] = 8'(i);
        end
    endfunction

    function void set_seed(logic [63:0] value);
        seed = value;
    endfunction

    function int pending();
        return pending_bytes.size();
    endfunction

    // xorshift64* step: advance the state, return the scrambled value
    function logic [63:0] next_draw();
        logic [63:0] x;
        x = gen_state;
        x ^= x >> 12;
        x ^= x << 25;
        x ^= x >> 27;
        gen_state = x;
        return x * DRAW_MULT;
    endfunction

    // identity fill, fisher-yates from the top entry down, then the inverse
    function void shuffle_maps();
        logic [63:0] start;
        logic [63:0] span;
        logic [7:0]  pick;
        logic [7:0]  hold;
        start = seed ^ SEED_SALT;
        gen_state = (start == 64'd0) ? ZERO_SUB : start;
        for (int i = 0; i < 256; i++) begin
            fwd_map[i] = 8'(i);
        end
        for (int i = 256; i > 1; i--) begin
            span = 64'(i);
            pick = 8'(next_draw() % span);
            hold = fwd_map[i - 1];
            fwd_map[i - 1] = fwd_map[pick];
            fwd_map[pick]  = hold;
        end
        for (int i = 0; i < 256; i++) begin
            inv_map[fwd_map[i]] = 8'(i);
        end
    endfunction

    // one accepted input transfer: update the maps and queue the byte it must return
    function void predict_byte(t_command cmd, logic [7:0] value);
        logic [7:0] res;
        res = 8'd0;
        case (cmd)
            CMD_REBUILD: shuffle_maps();
            CMD_ENCODE:  res = fwd_map[value];
            CMD_DECODE:  res = inv_map[value];
            default:     res = 8'd0;
        endcase
        pending_bytes.insert(pending_bytes.size(), res);
    endfunction

    // one accepted output transfer against the oldest owed byte
    function void check_result(logic [7:0] actual);
        logic [7:0] want;
        if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN) begin
                $display("unexpected result byte %02h, nothing pending", actual);
            end
        end else begin
            want = pending_bytes.pop_front();
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= MISMATCH_SHOWN) begin
                    $display("result_byte mismatch: expected %02h, actual %02h", want, actual);
                end
            end
        end
    endfunction
endclass

module seeded_byte_permutation_tb;

    localparam int QUIET_LIMIT  = 150000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 476;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_command      = 2'd0;
    logic [7:0]        i_data_byte    = 8'd0;
    logic              o_out_valid;
    logic              i_out_ready    = 1'b0;
    logic [7:0]        o_result_byte;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    logic [SEED_W-1:0] i_shuffle_seed = '0;

    byte_map_scoreboard maps = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_granted   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    seeded_byte_permutation dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_byte  (o_result_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_shuffle_seed (i_shuffle_seed)
    );

    always #5 i_clk = ~i_clk;

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else if (hold_asked != hold_granted) begin
            hold_granted = hold_asked;
            hold_left    = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: every transfer goes to the scoreboard; watchdog on quiet cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                maps.check_result(o_result_byte);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                maps.set_seed(i_shuffle_seed);
            end
            if (i_in_valid && o_in_ready) begin
                maps.predict_byte(t_command'(i_command), i_data_byte);
            end
            if ((o_out_valid && i_out_ready) || (i_cfg_valid && o_cfg_ready) ||
                (i_in_valid && o_in_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input t_command cmd, input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering input and wait until every owed result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (maps.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // seed write while the block is idle
    task automatic write_seed(input logic [SEED_W-1:0] value);
        wait_drained();
        i_cfg_valid    <= 1'b1;
        i_shuffle_seed <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly lookups, some unused codes, rare rebuilds since each one is long
    function automatic t_command random_command();
        int r;
        r = $urandom_range(999);
        if (r < 4) begin
            return CMD_REBUILD;
        end else if (r < 60) begin
            return CMD_UNUSED;
        end else if (r < 530) begin
            return CMD_ENCODE;
        end else begin
            return CMD_DECODE;
        end
    endfunction

    // new seed, rebuild, then random lookups; optionally one long output hold-off
    task automatic run_random_phase(input int send_pct, input int recv_pct,
                                    input logic [SEED_W-1:0] seed, input bit with_hold);
        write_seed(seed);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        send_item(CMD_REBUILD, 8'($urandom_range(255)));
        for (int n = 1; n < PHASE_ITEMS; n++) begin
            if (with_hold && n == 50) begin
                hold_asked++;
            end
            send_item(random_command(), 8'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct  = 32;
        recv_stall_pct = 53;

        // maps are the identity right after reset
        send_item(CMD_ENCODE, 8'h00);
        send_item(CMD_ENCODE, 8'hFF);
        send_item(CMD_DECODE, 8'h00);
        send_item(CMD_DECODE, 8'hFF);
        send_item(CMD_UNUSED, 8'hA5);

        // seed equal to the salt: generator starts from the golden-ratio value
        write_seed(64'h00A5_A5DE_ADBE_EF42);
        send_item(CMD_ENCODE, 8'h5A);
        send_item(CMD_DECODE, 8'hC3);
        send_item(CMD_REBUILD, 8'hFF);
        send_item(CMD_ENCODE, 8'h00);
        send_item(CMD_ENCODE, 8'hFF);
        send_item(CMD_DECODE, 8'h00);
        send_item(CMD_DECODE, 8'hFF);
        send_item(CMD_UNUSED, 8'h00);

        // all-ones seed; the old map stays until the rebuild
        write_seed('1);
        send_item(CMD_DECODE, 8'h80);
        send_item(CMD_ENCODE, 8'h7F);
        send_item(CMD_REBUILD, 8'h00);
        send_item(CMD_ENCODE, 8'h01);
        send_item(CMD_DECODE, 8'hFE);
        send_item(CMD_UNUSED, 8'hFF);

        // random part: receiver stalls more, then sender idles more, then neither
        run_random_phase(32, 53, {$urandom, $urandom}, 1'b0);
        run_random_phase(53, 32, 64'd0, 1'b0);
        run_random_phase(0, 0, {$urandom, $urandom}, 1'b1);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (maps.mismatches == 0 && maps.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/sbp_pkg.sv
hdl/sbp_rng.sv
hdl/sbp_maps.sv
hdl/seeded_byte_permutation.sv
bench/seeded_byte_permutation_tb.sv
